/* hdl/tcfa_pkg.sv */
// Shared types and constants for the two-class age-ordered queue pair.
package tcfa_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ENQ     = 2'd0,
    ACT_DEQ0    = 2'd1,
    ACT_DEQ1    = 2'd2,
    ACT_DEQ_ANY = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_state_t;

endpackage

/* hdl/tcfa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module tcfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/tcfa_queue.sv */
// One class queue: head pointer, fill count and entry RAM read at the head.
module tcfa_queue
  import tcfa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic         pop_i,
  input  entry_t       wr_data_i,
  output entry_t       rd_data_o,
  output queue_state_t state_o
);

  localparam int unsigned SUM_W = CNT_W + 1;

  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] tail_sum;
  logic [PTR_W-1:0] tail;
  logic [$bits(entry_t)-1:0] rd_raw;

  assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
  assign tail = (tail_sum >= SUM_W'(QUEUE_DEPTH))
              ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
              : PTR_W'(tail_sum);

  assign state_o.empty = (count_q == '0);
  assign state_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (pop_i) begin
      head_d  = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
      count_d = count_q - CNT_W'(1);
    end else if (push_i) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  tcfa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (tail),
    .wdata_i (wr_data_i),
    .raddr_i (head_q),
    .rdata_o (rd_raw)
  );

  assign rd_data_o = entry_t'(rd_raw);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !state_o.full && !pop_i)
    else $error("push into full queue or push with pop");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !state_o.empty)
    else $error("pop from empty queue");

endmodule

/* hdl/two_class_fifo_age_arbiter.sv */
// Top level: command FSM, age arbitration and the two class queues.
// A command accepted in S_IDLE executes in S_EXEC, which registers its result strobe (done_o).
// Commands are taken only in S_IDLE, not during S_EXEC, which uses the registered head RAM read.
// busy_o is high for the one cycle the command executes; results cannot be stalled.
// Reset (rst_ni low, asynchronous) empties both queues and clears the arrival stamp counter.
// No clearing pass: queue RAM contents are only read once written.
module two_class_fifo_age_arbiter
  import tcfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          action_i,
  input  logic                item_class_i,
  input  logic [TAG_BITS-1:0] item_tag_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [TAG_BITS-1:0] out_tag_o,
  output logic                out_class_o,
  output logic [STAMP_W-1:0]  out_stamp_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e              state_q;
  action_e             action_q;
  logic                class_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [STAMP_W-1:0]  stamp_cnt_q, stamp_cnt_d;

  logic                done_q;
  status_e             status_q, status_d;
  logic [TAG_BITS-1:0] out_tag_q, out_tag_d;
  logic                out_class_q, out_class_d;
  logic [STAMP_W-1:0]  out_stamp_q, out_stamp_d;

  logic         push0, push1, pop0, pop1;
  entry_t       wr_entry, head0, head1, head_sel;
  queue_state_t qs0, qs1;
  logic         sel1, sel_empty, exec;
  logic [STAMP_W-1:0] age_diff;

  assign exec     = (state_q == S_EXEC);
  assign wr_entry = '{tag: tag_q, stamp: stamp_cnt_q};
  assign age_diff = head0.stamp - head1.stamp;

  always_comb begin
    case (action_q)
      ACT_DEQ0:    sel1 = 1'b0;
      ACT_DEQ1:    sel1 = 1'b1;
      ACT_DEQ_ANY: begin
        if (qs0.empty) begin
          sel1 = 1'b1;
        end else if (qs1.empty) begin
          sel1 = 1'b0;
        end else begin
          sel1 = !age_diff[STAMP_W-1];
        end
      end
      default:     sel1 = class_q;
    endcase
  end

  assign sel_empty = sel1 ? qs1.empty : qs0.empty;
  assign head_sel  = sel1 ? head1 : head0;

  always_comb begin
    push0       = 1'b0;
    push1       = 1'b0;
    pop0        = 1'b0;
    pop1        = 1'b0;
    stamp_cnt_d = stamp_cnt_q;
    status_d    = ST_OK;
    out_tag_d   = '0;
    out_class_d = 1'b0;
    out_stamp_d = '0;
    if (action_q == ACT_ENQ) begin
      if (class_q ? qs1.full : qs0.full) begin
        status_d = ST_FULL;
      end else begin
        push0       = exec && !class_q;
        push1       = exec && class_q;
        out_stamp_d = stamp_cnt_q;
        stamp_cnt_d = exec ? stamp_cnt_q + STAMP_W'(1) : stamp_cnt_q;
      end
    end else if (sel_empty) begin
      status_d = ST_EMPTY;
    end else begin
      pop0        = exec && !sel1;
      pop1        = exec && sel1;
      out_tag_d   = head_sel.tag;
      out_class_d = sel1;
      out_stamp_d = head_sel.stamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      action_q    <= ACT_ENQ;
      class_q     <= 1'b0;
      tag_q       <= '0;
      stamp_cnt_q <= '0;
      done_q      <= 1'b0;
      status_q    <= ST_OK;
      out_tag_q   <= '0;
      out_class_q <= 1'b0;
      out_stamp_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            action_q <= action_e'(action_i);
            class_q  <= item_class_i;
            tag_q    <= item_tag_i;
            state_q  <= S_EXEC;
          end
        end
        S_EXEC: begin
          stamp_cnt_q <= stamp_cnt_d;
          done_q      <= 1'b1;
          status_q    <= status_d;
          out_tag_q   <= out_tag_d;
          out_class_q <= out_class_d;
          out_stamp_q <= out_stamp_d;
          state_q     <= S_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  tcfa_queue u_queue0 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push0),
    .pop_i     (pop0),
    .wr_data_i (wr_entry),
    .rd_data_o (head0),
    .state_o   (qs0)
  );

  tcfa_queue u_queue1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push1),
    .pop_i     (pop1),
    .wr_data_i (wr_entry),
    .rd_data_o (head1),
    .state_o   (qs1)
  );

  assign busy_o      = exec;
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_tag_o   = out_tag_q;
  assign out_class_o = out_class_q;
  assign out_stamp_o = out_stamp_q;

  a_exec_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> done_o)
    else $error("executed command gave no result");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not execute");

  a_one_queue_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({push0, push1, pop0, pop1}) <= 1)
    else $error("more than one queue operation in a cycle");

  a_stamp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push0 || push1) |=> stamp_cnt_q == $past(stamp_cnt_q) + STAMP_W'(1))
    else $error("stamp counter did not advance on enqueue");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> out_stamp_o == '0 && out_tag_o == '0)
    else $error("failed command returned nonzero payload");

endmodule
